// ----- rtl/pta_pkg.sv -----
// Shared constants, command and status codes, and controller types for the page-table allocator.
package pta_pkg;

   // Default number of second-level tables and fixed number of entries per table.
   localparam int TABLE_COUNT_DEF   = 4;
   localparam int ENTRIES_PER_TABLE = 1024;

   // Command codes carried on req_tuser.
   localparam logic [3:0] CMD_MAP     = 4'd0;
   localparam logic [3:0] CMD_LOOKUP  = 4'd1;
   localparam logic [3:0] CMD_SETF    = 4'd2;
   localparam logic [3:0] CMD_GETD    = 4'd3;
   localparam logic [3:0] CMD_SETD    = 4'd4;
   localparam logic [3:0] CMD_PRESENT = 4'd5;
   localparam logic [3:0] CMD_ABSENT  = 4'd6;
   localparam logic [3:0] CMD_ALLOC   = 4'd7;
   localparam logic [3:0] CMD_COUNT   = 4'd8;

   // Status codes carried on rsp_tuser.
   localparam logic [1:0] STAT_OK    = 2'd0;
   localparam logic [1:0] STAT_OOM   = 2'd1;
   localparam logic [1:0] STAT_RANGE = 2'd2;

   localparam logic [11:0] RESET_PAGE_FLAGS = 12'h002;
   localparam logic [11:0] RESET_DIR_FLAGS  = 12'h003;
   localparam logic [12:0] COUNT_MAX        = 13'h1FFF;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_EXEC,
      ST_RESP
   } pta_state_type;

   // Controller to datapath.
   typedef struct packed {
      logic clear_step;
      logic load;
      logic read;
      logic exec;
      logic emit;
   } pta_ctl_type;

   // Datapath to controller.
   typedef struct packed {
      logic clear_done;
      logic direct;
      logic last;
      logic out_free;
   } pta_sts_type;

endpackage

// ----- rtl/pta_datapath.sv -----
// Datapath of the page-table allocator: entry and directory memories, walk registers, output stage.
module pta_datapath
   import pta_pkg::*;
#(
   parameter int TABLE_COUNT = TABLE_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  pta_ctl_type ctl,
   output pta_sts_type sts,
   input  logic [79:0] req_tdata,
   input  logic [3:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,
   output logic [1:0]  rsp_tuser
);

   localparam int PAGE_TOTAL = TABLE_COUNT * ENTRIES_PER_TABLE;
   localparam int PW = $clog2(PAGE_TOTAL);
   localparam int TW = (TABLE_COUNT > 1) ? $clog2(TABLE_COUNT) : 1;
   localparam int CW = $clog2(PAGE_TOTAL + 1);
   localparam int RW = PW + 1;
   localparam int MW = (RW > 13) ? RW : 13;
   localparam int XW = (CW > 13) ? CW : 13;
   localparam logic [PW-1:0] LAST_PAGE   = PW'(PAGE_TOTAL - 1);
   localparam logic [20:0]   PAGE_LIMIT  = 21'(PAGE_TOTAL);

   logic [31:0] page_mem [PAGE_TOTAL];
   logic [11:0] dir_mem [TABLE_COUNT];

   logic [3:0]    cmd_ff, cmd_in;
   logic [TW-1:0] tbl_ff, tbl_in;
   logic [19:0]   frame_ff, frame_in;
   logic [11:0]   flags_ff, flags_in;
   logic [12:0]   cnt_ff, cnt_in;
   logic [PW-1:0] addr_ff, addr_in;
   logic [PW-1:0] start_ff, start_in;
   logic [RW-1:0] run_ff, run_in;
   logic          mark_ff, mark_in;
   logic [CW-1:0] total_ff, total_in;
   logic [19:0]   res_frame_ff, res_frame_in;
   logic [11:0]   res_flags_ff, res_flags_in;
   logic [31:0]   res_run_ff, res_run_in;
   logic [12:0]   res_count_ff, res_count_in;
   logic [1:0]    res_stat_ff, res_stat_in;
   logic [31:0]   rd_page_ff;
   logic [11:0]   rd_dir_ff;
   logic          rsp_valid_ff;
   logic [79:0]   rsp_data_ff;
   logic [1:0]    rsp_stat_ff;

   logic [31:0]   in_virt;
   logic          in_range;
   logic          in_count_zero;
   logic          direct;
   logic          page_we;
   logic [PW-1:0] wr_addr;
   logic [31:0]   wr_data;
   logic          dir_we;
   logic [TW-1:0] dir_waddr;
   logic [11:0]   dir_wdata;
   logic          last;
   logic [RW-1:0] run_next;
   logic [PW-1:0] found_start;

   assign in_virt       = req_tdata[31:0];
   assign in_range      = {1'b0, in_virt[31:12]} < PAGE_LIMIT;
   assign in_count_zero = (req_tdata[76:64] == 13'd0);
   assign run_next      = rd_page_ff[0] ? '0 : run_ff + 1'b1;
   assign found_start   = addr_ff + 1'b1 - PW'(cnt_ff);

   // Table index in range is the same test as page index in range.
   always_comb begin
      direct = 1'b1;
      unique case (req_tuser)
         CMD_MAP, CMD_LOOKUP, CMD_SETF, CMD_GETD, CMD_SETD: direct = !in_range;
         CMD_PRESENT, CMD_ABSENT: direct = in_count_zero || !in_range;
         CMD_ALLOC: direct = in_count_zero;
         default: direct = 1'b1;
      endcase
   end

   assign sts.direct     = direct;
   assign sts.clear_done = (addr_ff == LAST_PAGE);
   assign sts.last       = last;
   assign sts.out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      cmd_in       = cmd_ff;
      tbl_in       = tbl_ff;
      frame_in     = frame_ff;
      flags_in     = flags_ff;
      cnt_in       = cnt_ff;
      addr_in      = addr_ff;
      start_in     = start_ff;
      run_in       = run_ff;
      mark_in      = mark_ff;
      res_frame_in = res_frame_ff;
      res_flags_in = res_flags_ff;
      res_run_in   = res_run_ff;
      res_count_in = res_count_ff;
      res_stat_in  = res_stat_ff;
      page_we      = 1'b0;
      wr_addr      = addr_ff;
      wr_data      = rd_page_ff;
      dir_we       = 1'b0;
      dir_waddr    = tbl_ff;
      dir_wdata    = flags_ff;
      last         = 1'b0;

      if (ctl.clear_step) begin
         page_we = 1'b1;
         wr_data = {20'(addr_ff), RESET_PAGE_FLAGS};
         addr_in = addr_ff + 1'b1;
         if (int'(addr_ff) < TABLE_COUNT) begin
            dir_we    = 1'b1;
            dir_waddr = addr_ff[TW-1:0];
            dir_wdata = RESET_DIR_FLAGS;
         end
      end

      if (ctl.load) begin
         cmd_in       = req_tuser;
         tbl_in       = in_virt[22 +: TW];
         frame_in     = req_tdata[51:32];
         flags_in     = req_tdata[63:52];
         cnt_in       = req_tdata[76:64];
         addr_in      = (req_tuser == CMD_ALLOC) ? '0 : in_virt[12 +: PW];
         run_in       = '0;
         mark_in      = 1'b0;
         res_frame_in = '0;
         res_flags_in = '0;
         res_run_in   = '0;
         res_count_in = '0;
         res_stat_in  = STAT_OK;
         unique case (req_tuser)
            CMD_MAP, CMD_LOOKUP, CMD_SETF, CMD_GETD, CMD_SETD: begin
               if (!in_range) res_stat_in = STAT_RANGE;
            end
            CMD_PRESENT, CMD_ABSENT: begin
               if (!in_count_zero && !in_range) res_stat_in = STAT_RANGE;
            end
            CMD_COUNT: begin
               res_count_in = (XW'(total_ff) > XW'(COUNT_MAX)) ? COUNT_MAX : 13'(total_ff);
            end
            default: res_stat_in = STAT_OK;
         endcase
      end

      if (ctl.exec) begin
         unique case (cmd_ff)
            CMD_MAP: begin
               page_we = 1'b1;
               wr_data = {frame_ff, flags_ff};
               last    = 1'b1;
            end
            CMD_LOOKUP: begin
               res_frame_in = rd_page_ff[31:12];
               res_flags_in = rd_page_ff[11:0];
               last         = 1'b1;
            end
            CMD_SETF: begin
               page_we = 1'b1;
               wr_data = {rd_page_ff[31:12], flags_ff};
               last    = 1'b1;
            end
            CMD_GETD: begin
               res_flags_in = rd_dir_ff;
               last         = 1'b1;
            end
            CMD_SETD: begin
               dir_we = 1'b1;
               last   = 1'b1;
            end
            CMD_PRESENT, CMD_ABSENT: begin
               page_we = 1'b1;
               wr_data = {rd_page_ff[31:1], cmd_ff == CMD_PRESENT};
               cnt_in  = cnt_ff - 1'b1;
               addr_in = addr_ff + 1'b1;
               if (cnt_ff == 13'd1) begin
                  last = 1'b1;
               end else if (addr_ff == LAST_PAGE) begin
                  last        = 1'b1;
                  res_stat_in = STAT_RANGE;
               end
            end
            CMD_ALLOC: begin
               if (mark_ff) begin
                  page_we = 1'b1;
                  wr_data = {rd_page_ff[31:1], 1'b1};
                  cnt_in  = cnt_ff - 1'b1;
                  addr_in = addr_ff + 1'b1;
                  if (cnt_ff == 13'd1) begin
                     last       = 1'b1;
                     res_run_in = {20'(start_ff), 12'd0};
                  end
               end else begin
                  run_in = run_next;
                  if (MW'(run_next) == MW'(cnt_ff)) begin
                     mark_in  = 1'b1;
                     addr_in  = found_start;
                     start_in = found_start;
                  end else if (addr_ff == LAST_PAGE) begin
                     last        = 1'b1;
                     res_stat_in = STAT_OOM;
                  end else begin
                     addr_in = addr_ff + 1'b1;
                  end
               end
            end
            default: last = 1'b1;
         endcase
      end
   end

   always_comb begin
      total_in = total_ff;
      if (page_we && !ctl.clear_step) begin
         if (rd_page_ff[0] && !wr_data[0]) total_in = total_ff - 1'b1;
         else if (!rd_page_ff[0] && wr_data[0]) total_in = total_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (page_we) page_mem[wr_addr] <= wr_data;
      if (dir_we) dir_mem[dir_waddr] <= dir_wdata;
      if (ctl.read) begin
         rd_page_ff <= page_mem[addr_ff];
         rd_dir_ff  <= dir_mem[tbl_ff];
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      tbl_ff       <= tbl_in;
      frame_ff     <= frame_in;
      flags_ff     <= flags_in;
      cnt_ff       <= cnt_in;
      start_ff     <= start_in;
      run_ff       <= run_in;
      mark_ff      <= mark_in;
      res_frame_ff <= res_frame_in;
      res_flags_ff <= res_flags_in;
      res_run_ff   <= res_run_in;
      res_count_ff <= res_count_in;
      res_stat_ff  <= res_stat_in;
      if (ctl.emit) begin
         rsp_data_ff <= {3'd0, res_count_ff, res_run_ff, res_flags_ff, res_frame_ff};
         rsp_stat_ff <= res_stat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff      <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         addr_ff  <= addr_in;
         total_ff <= total_in;
         if (ctl.emit) rsp_valid_ff <= 1'b1;
         else if (rsp_tready) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_stat_ff;

`ifndef SYNTHESIS
   a_total_bounded: assert property (@(posedge clock) disable iff (reset)
      int'(total_ff) <= PAGE_TOTAL)
      else $error("present page total exceeds page count");
   a_valid_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(ctl.emit))
      else $error("response raised without emit");
   a_mark_count: assert property (@(posedge clock) disable iff (reset)
      (ctl.exec && mark_ff) |-> (cnt_ff != 13'd0))
      else $error("allocation marking with empty count");
`endif

endmodule

// ----- rtl/pta_controller.sv -----
// Controller state machine of the page-table allocator.
module pta_controller
   import pta_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  pta_sts_type sts,
   output pta_ctl_type ctl
);

   pta_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      ctl        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            ctl.clear_step = 1'b1;
            if (sts.clear_done) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               ctl.load = 1'b1;
               state_in = sts.direct ? ST_RESP : ST_READ;
            end
         end
         ST_READ: begin
            ctl.read = 1'b1;
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            ctl.exec = 1'b1;
            state_in = sts.last ? ST_RESP : ST_READ;
         end
         ST_RESP: begin
            if (sts.out_free) begin
               ctl.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

endmodule

// ----- rtl/page_table_allocator_unit.sv -----
// Top level of the page-table allocator: controller and datapath.
//
// One request transfer on the req_ channel carries a command (req_tuser) and its operands
// (req_tdata); exactly one response transfer on the rsp_ channel returns the result fields
// (rsp_tdata) and a status code (rsp_tuser). Requests are handled one at a time.
// Commands that need no table access (count, zero-length runs, range errors, unknown codes)
// skip the memory read and go from the request transfer to the response stage. Map, lookup,
// set flags and the directory commands take one read of the entry and directory memories,
// one update and one response. Present and absent walks take a read and a write of the
// single-port entry memory for each page. Allocation scans from page zero, a page at a time,
// until a free run is found, then marks that run page by page.
// After reset the block sweeps the entry memory and directory flags to their initial
// values, one entry per cycle, with req_tready low throughout.
// The response sits in an output register: while the receiver stalls, the block still
// takes and processes the next request and holds its result until the register frees.
module page_table_allocator_unit
   import pta_pkg::*;
#(
   parameter int TABLE_COUNT = TABLE_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // virt_addr[31:0], frame_number[51:32], flag_bits[63:52], page_count[76:64], zero fill
   input  logic [79:0] req_tdata,
   // cmd[3:0]
   input  logic [3:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // out_frame[19:0], out_flags[31:20], run_address[63:32], present_count[76:64], zero fill
   output logic [79:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]  rsp_tuser
);

   pta_ctl_type ctl;
   pta_sts_type sts;

   pta_controller u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .ctl        (ctl)
   );

   pta_datapath #(
      .TABLE_COUNT (TABLE_COUNT)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .sts        (sts),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule
